// ===== src/array_lifo_stack_unit_assert.svh =====
// assertion macros shared by the stack unit
`ifndef ARRAY_LIFO_STACK_UNIT_ASSERT_SVH
`define ARRAY_LIFO_STACK_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset only
`define ALSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// next-cycle implication, checked out of reset only
`define ALSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`endif

// ===== src/alsu_pkg.sv =====
`default_nettype none

package alsu_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned POS_W  = 5;
	localparam int unsigned LIM_W  = 5;
	localparam int unsigned FILL_W = 5;
	localparam int unsigned STAT_W = 2;

	localparam logic [LIM_W-1:0] LIMIT_RST = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_PEEK   = 3'd2,
		OP_TOP    = 3'd3,
		OP_BOTTOM = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_BADPOS = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

endpackage

`default_nettype wire

// ===== src/array_lifo_stack_unit.sv =====
// Bounded LIFO stack of signed 32-bit words held in a single-port-write,
// single-port-read synchronous RAM.
// Input channel: in_valid / in_stall with op, push_value, position. A beat is
// taken when in_valid is high and in_stall low. Ops: push, pop, peek (1 is
// the top entry), read top, read bottom.
// Output channel: out_valid / out_stall with data, status, fill_count,
// is_empty, is_full. Exactly one result beat per input beat, in order.
// Configuration: cfg_we writes cfg_wdata into the capacity register; 0 acts
// as 1 and values above DEPTH act as DEPTH. Write only while idle.
// The RAM read is issued and the read stage loaded when the input beat is
// taken; the output register loads from them in S_READ once it is free.
// A new input beat is not taken until the previous item has moved from the
// read stage to the output register; the fill count is updated at accept,
// the RAM read completes in the following cycle.
// If the receiver stalls, the finished result waits in the output register
// and the next input beat is still taken; that item then holds in the read
// stage until the output register frees up.
// Reset clears the fill count, sets capacity to 16 and empties the output
// register. RAM contents are not cleared; only entries below the fill count
// are ever read.
`default_nettype none

module array_lifo_stack_unit
	import alsu_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic        [LIM_W-1:0]  cfg_wdata,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic        [OP_W-1:0]   op,
	input  wire logic signed [DATA_W-1:0] push_value,
	input  wire logic        [POS_W-1:0]  position,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed      [DATA_W-1:0] data,
	output logic             [STAT_W-1:0] status,
	output logic             [FILL_W-1:0] fill_count,
	output logic                          is_empty,
	output logic                          is_full
);

`include "array_lifo_stack_unit_assert.svh"

	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned WIDE  = (CNT_W > FILL_W) ? CNT_W : FILL_W;

	state_t state_q, state_nx;

	logic [LIM_W-1:0] limit_q;
	logic [CNT_W-1:0] count_q;

	logic accept, ld_out;

	// decode of the item at accept
	logic [WIDE-1:0] cnt_w, pos_w, lim_w, cap_w, cnt_nx, ra_w;
	status_t         stat_nx;
	logic            rd_nx, wr_nx;

	// read stage
	status_t         stat_s1;
	logic            rd_s1, empty_s1, full_s1;
	logic [WIDE-1:0] cnt_s1;

	logic [DATA_W-1:0] rdata;

	// output register
	logic              out_valid_q;
	logic [DATA_W-1:0] data_q;
	status_t           stat_q;
	logic [FILL_W-1:0] fill_q;
	logic              empty_q, full_q;

	assign cnt_w = WIDE'(count_q);
	assign pos_w = WIDE'(position);
	assign lim_w = WIDE'(limit_q);

	always_comb begin
		priority if (limit_q == '0) begin
			cap_w = WIDE'(1);
		end else if (lim_w > WIDE'(DEPTH)) begin
			cap_w = WIDE'(DEPTH);
		end else begin
			cap_w = lim_w;
		end
	end

	always_comb begin
		stat_nx = STAT_OK;
		cnt_nx  = cnt_w;
		rd_nx   = 1'b0;
		wr_nx   = 1'b0;
		ra_w    = '0;
		unique case (op)
			OP_PUSH: begin
				if (cnt_w >= cap_w) begin
					stat_nx = STAT_FULL;
				end else begin
					wr_nx  = 1'b1;
					cnt_nx = cnt_w + WIDE'(1);
				end
			end
			OP_POP: begin
				if (cnt_w == '0) begin
					stat_nx = STAT_EMPTY;
				end else begin
					rd_nx  = 1'b1;
					ra_w   = cnt_w - WIDE'(1);
					cnt_nx = cnt_w - WIDE'(1);
				end
			end
			OP_PEEK: begin
				priority if (cnt_w == '0) begin
					stat_nx = STAT_EMPTY;
				end else if (pos_w == '0 || pos_w > cnt_w) begin
					stat_nx = STAT_BADPOS;
				end else begin
					rd_nx = 1'b1;
					ra_w  = cnt_w - pos_w;
				end
			end
			OP_TOP: begin
				if (cnt_w == '0) begin
					stat_nx = STAT_EMPTY;
				end else begin
					rd_nx = 1'b1;
					ra_w  = cnt_w - WIDE'(1);
				end
			end
			OP_BOTTOM: begin
				if (cnt_w == '0) begin
					stat_nx = STAT_EMPTY;
				end else begin
					rd_nx = 1'b1;
				end
			end
			default: begin
				stat_nx = STAT_BADPOS;
			end
		endcase
	end

	// only one item is taken at a time (input stalls in S_READ), so a push always lands before any later read
	alsu_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (accept && wr_nx),
		.waddr(count_q[AW-1:0]),
		.wdata(push_value),
		.re   (accept && rd_nx),
		.raddr(ra_w[AW-1:0]),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nx = S_READ;
				end
			end
			S_READ: begin
				if (ld_out) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall = (state_q != S_IDLE);
		ld_out   = (state_q == S_READ) && (!out_valid_q || !out_stall);
		accept   = in_valid && (state_q == S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= LIMIT_RST;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (accept) begin
				count_q <= cnt_nx[CNT_W-1:0];
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stat_s1  <= stat_nx;
			rd_s1    <= rd_nx;
			cnt_s1   <= cnt_nx;
			empty_s1 <= (cnt_nx == '0);
			full_s1  <= (cnt_nx >= cap_w);
		end
		if (ld_out) begin
			data_q  <= rd_s1 ? rdata : '0;
			stat_q  <= stat_s1;
			fill_q  <= cnt_s1[FILL_W-1:0];
			empty_q <= empty_s1;
			full_q  <= full_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign data       = data_q;
	assign status     = stat_q;
	assign fill_count = fill_q;
	assign is_empty   = empty_q;
	assign is_full    = full_q;

	`ALSU_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`ALSU_ASSERT_NEXT(a_accept_to_read, clk, arst_n, accept, state_q == S_READ)
	`ALSU_ASSERT_NOW(a_read_blocks_input, clk, arst_n, state_q == S_READ, in_stall)
	`ALSU_ASSERT_NEXT(a_reject_keeps_count, clk, arst_n, accept && stat_nx != STAT_OK, count_q == $past(count_q))
	`ALSU_ASSERT_NOW(a_result_from_read, clk, arst_n, $rose(out_valid_q), $past(state_q == S_READ))

endmodule

`default_nettype wire

// ===== src/alsu_mem.sv =====
`default_nettype none

module alsu_mem
	import alsu_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read, so a stalled result stays put
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== tb/array_lifo_stack_unit_tb.sv =====
`timescale 1ns / 1ps

module array_lifo_stack_unit_tb;
	import alsu_pkg::*;

	localparam logic [OP_W-1:0] OP_UNDEF_FIRST = OP_W'(OP_BOTTOM + 1);
	localparam logic [OP_W-1:0] OP_UNDEF_LAST  = '1;

	localparam int unsigned IDLE_NONE     = 0;
	localparam int unsigned IDLE_SENDER   = 1;
	localparam int unsigned IDLE_RECEIVER = 2;
	localparam int unsigned IDLE_BOTH     = 3;

	localparam int unsigned SHOWN_MISMATCHES = 10;

	typedef struct {
		logic signed [DATA_W-1:0] data;
		logic        [STAT_W-1:0] status;
		logic        [FILL_W-1:0] fill;
		logic                     empty;
		logic                     full;
	} stack_result_t;

	class lifo_scoreboard;
		logic signed [DATA_W-1:0] words [DEPTH_DEF];
		int unsigned              held;
		logic [LIM_W-1:0]         limit_reg;
		stack_result_t            awaited [$];
		int unsigned              mismatches;
		int unsigned              checked;

		function new();
			held = 0;
			limit_reg = LIMIT_RST;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_limit(input logic [LIM_W-1:0] v);
			limit_reg = v;
		endfunction

		// out-of-range limits clamp to 1..DEPTH
		function int unsigned capacity();
			if (limit_reg == 0)
				return 1;
			if (limit_reg > DEPTH_DEF)
				return DEPTH_DEF;
			return limit_reg;
		endfunction

		function void take_beat(input logic [OP_W-1:0] code, input logic signed [DATA_W-1:0] val,
				input logic [POS_W-1:0] pos);
			stack_result_t r;
			int unsigned   cap;
			cap = capacity();
			r.data = '0;
			r.status = STAT_OK;
			if (code == OP_PUSH) begin
				if (held >= cap) begin
					r.status = STAT_FULL;
				end else begin
					words[held] = val;
					held++;
				end
			end else if (code > OP_BOTTOM) begin
				r.status = STAT_BADPOS;
			end else if (held == 0) begin
				// empty check wins over the position check
				r.status = STAT_EMPTY;
			end else begin
				case (code)
					OP_POP: begin
						held--;
						r.data = words[held];
					end
					OP_PEEK: begin
						if (pos == 0 || pos > held)
							r.status = STAT_BADPOS;
						else
							r.data = words[held - pos];
					end
					OP_TOP: r.data = words[held - 1];
					default: r.data = words[0];
				endcase
			end
			r.fill = held[FILL_W-1:0];
			r.empty = (held == 0);
			r.full = (held >= cap);
			awaited.push_back(r);
		endfunction

		function void check_beat(input stack_result_t got);
			stack_result_t want;
			checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("result beat %0d with nothing outstanding: data %0d status %0d",
						checked, got.data, got.status);
				return;
			end
			want = awaited.pop_front();
			if (got.data !== want.data || got.status !== want.status || got.fill !== want.fill
					|| got.empty !== want.empty || got.full !== want.full) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES) begin
					$display("result beat %0d: expected data %0d status %0d fill %0d %s",
						checked, want.data, want.status, want.fill, "empty/full");
					$display("  expected %b/%b, got data %0d status %0d fill %0d",
						want.empty, want.full, got.data, got.status, got.fill);
					$display("  got empty/full %b/%b", got.empty, got.full);
				end
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic        [LIM_W-1:0]  cfg_wdata;
	logic                     in_valid;
	logic                     in_stall;
	logic        [OP_W-1:0]   op;
	logic signed [DATA_W-1:0] push_value;
	logic        [POS_W-1:0]  position;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] data;
	logic        [STAT_W-1:0] status;
	logic        [FILL_W-1:0] fill_count;
	logic                     is_empty;
	logic                     is_full;

	lifo_scoreboard board;
	int unsigned    beats_in = 0;
	int unsigned    send_idle_pct = 0;
	int unsigned    stall_pct = 0;
	int unsigned    push_bias = 75;
	int unsigned    settings_used = 1;

	logic [LIM_W-1:0] phase_limit [7] = '{5'd0, 5'd31, 5'd5, 5'd16, 5'd1, 5'd20, 5'd9};
	int unsigned      phase_mode  [7] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
		IDLE_NONE, IDLE_RECEIVER, IDLE_SENDER};
	int unsigned      phase_items [7] = '{40, 100, 80, 100, 40, 80, 60};

	array_lifo_stack_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.push_value (push_value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data       (data),
		.status     (status),
		.fill_count (fill_count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : monitor
		stack_result_t got;
		if (arst_n) begin
			if (cfg_we)
				board.write_limit(cfg_wdata);
			if (in_valid && !in_stall) begin
				board.take_beat(op, push_value, position);
				beats_in <= beats_in + 1;
			end
			if (out_valid && !out_stall) begin
				got.data = data;
				got.status = status;
				got.fill = fill_count;
				got.empty = is_empty;
				got.full = is_full;
				board.check_beat(got);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_beat(input logic [OP_W-1:0] code, input logic signed [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos);
		int unsigned seen;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		seen = beats_in;
		in_valid <= 1'b1;
		op <= code;
		push_value <= val;
		position <= pos;
		do @(negedge clk); while (beats_in == seen);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(negedge clk);
		// extra idle time once the read and output stages have drained
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [LIM_W-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic set_idling(input int unsigned mode);
		case (mode)
			IDLE_SENDER: begin
				send_idle_pct = 71;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct = 71;
			end
			IDLE_BOTH: begin
				send_idle_pct = 6;
				stall_pct = 6;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	task automatic random_beat();
		logic [OP_W-1:0]          code;
		logic signed [DATA_W-1:0] val;
		logic [POS_W-1:0]         pos;
		int unsigned              held;
		held = board.held;
		// swing between filling and draining runs so full and empty both get reached
		if ($urandom_range(11) == 0)
			push_bias = 100 - push_bias;
		if ($urandom_range(99) < 4) begin
			code = OP_W'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
		end else if ($urandom_range(99) < push_bias) begin
			code = OP_PUSH;
		end else begin
			case ($urandom_range(3))
				0: code = OP_POP;
				1: code = OP_PEEK;
				2: code = OP_TOP;
				default: code = OP_BOTTOM;
			endcase
		end
		val = $urandom;
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: val = {1'b1, {(DATA_W-1){1'b0}}};
				1: val = {1'b0, {(DATA_W-1){1'b1}}};
				2: val = '1;
				default: val = '0;
			endcase
		end
		if (held != 0 && $urandom_range(9) < 8)
			pos = POS_W'($urandom_range(held, 1));
		else
			pos = POS_W'($urandom_range((1 << POS_W) - 1));
		send_beat(code, val, pos);
	endtask

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = OP_PUSH;
		push_value = '0;
		position = '0;
		out_stall = 1'b0;
		board = new();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty stack: every read is rejected, position is not looked at
		send_beat(OP_TOP, '0, '0);
		send_beat(OP_POP, '0, '0);
		send_beat(OP_PEEK, '0, '0);
		send_beat(OP_BOTTOM, '0, '0);
		send_beat(OP_UNDEF_FIRST, '0, '0);
		send_beat(OP_PUSH, {1'b1, {(DATA_W-1){1'b0}}}, '0);
		send_beat(OP_PUSH, {1'b0, {(DATA_W-1){1'b1}}}, '1);
		send_beat(OP_PUSH, '1, '0);
		send_beat(OP_PUSH, '0, '0);
		send_beat(OP_PEEK, '1, 5'd0);
		send_beat(OP_PEEK, '0, 5'd1);
		send_beat(OP_PEEK, '0, 5'd4);
		send_beat(OP_PEEK, '0, 5'd5);
		send_beat(OP_PEEK, '0, '1);
		send_beat(OP_TOP, '0, '0);
		send_beat(OP_BOTTOM, '0, '0);
		send_beat(OP_UNDEF_LAST, '1, '1);

		// capacity dropped under the fill count: entries stay, pushes refused until pops bring the fill count under it
		write_capacity(5'd2);
		send_beat(OP_PUSH, 32'sh1234_5678, '0);
		send_beat(OP_TOP, '0, '0);
		send_beat(OP_POP, '0, '0);
		send_beat(OP_POP, '0, '0);
		send_beat(OP_POP, '0, '0);
		send_beat(OP_PUSH, 32'sh0bad_cafe, '0);
		send_beat(OP_PUSH, 32'sh7654_3210, '0);

		for (int p = 0; p < 7; p++) begin
			write_capacity(phase_limit[p]);
			set_idling(phase_mode[p]);
			for (int i = 0; i < phase_items[p]; i++) begin
				if (p == 3 && i == phase_items[p] / 2)
					drain_results();
				random_beat();
			end
		end

		drain_results();
		$display("covered %0d stack operations and %0d checked result beats", beats_in,
			board.checked);
		$display("over %0d capacity settings with idle and stall patterns on both channels",
			settings_used);
		if (board.mismatches == 0 && board.awaited.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
